@@ sv/tdsb_pkg.sv @@
package tdsb_pkg;

  // Input kinds carried on the slave-side tuser.
  typedef enum logic [2:0] {
    OP_COMMAND    = 3'd0,
    OP_STATE_TICK = 3'd1,
    OP_CTRL_TICK  = 3'd2,
    OP_LEFT_PULSE = 3'd3,
    OP_RIGHT_PULSE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REST = 2'd1,
    MODE_FWD  = 2'd2,
    MODE_BACK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_BACK = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  // Command characters.
  localparam logic [7:0] CMD_FWD  = 8'h66;
  localparam logic [7:0] CMD_STOP = 8'h73;
  localparam logic [7:0] CMD_BACK = 8'h62;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_TICKS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REST_TICKS = 1'b1;

  localparam logic [7:0] MOVE_TICKS_RESET = 8'd10;
  localparam logic [7:0] REST_TICKS_RESET = 8'd5;

  localparam int unsigned PULSE_COUNT_WIDTH_DEF = 16;

  // Port widths.
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] cmd_code;
    logic [7:0] pwm_value;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    mode_t      mode;
  } result_t;

endpackage

@@ sv/timed_drive_with_speed_balance.sv @@
// Two-wheel timed drive controller with right-wheel speed balancing.
//
// Input words arrive on the slave-side stream. tuser carries the word's
// kind (command, state tick, control tick, left pulse, right pulse) and
// tdata carries the command character and the requested duty. Every input
// word produces exactly one result word on the master-side stream, holding
// the drive action, both duties and the drive mode after the word.
//
// A word accepted into the input register is processed by the state update
// logic and presented from the result register. Throughput is one word per
// cycle while the receiver takes results; the drive state is the only loop.
//
// When the receiver stalls, the result register holds its word and the
// input register can still take one more word, after which s_tready drops
// until the result is taken. Reset clears the drive state, pulse counts,
// speeds and both pipeline valid flags and restores the tick registers to
// their defaults (10 move ticks, 5 rest ticks). The tick registers may be
// rewritten through cfg_we/cfg_index/cfg_data while the block is idle.
module timed_drive_with_speed_balance #(
  parameter int unsigned PULSE_COUNT_WIDTH = tdsb_pkg::PULSE_COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tdsb_pkg::CFG_INDEX_W-1:0] cfg_index,  // 0 move_ticks, 1 rest_ticks
  input  logic [7:0]                    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tdsb_pkg::IN_DATA_W-1:0]  s_tdata,     // cmd_code[7:0], pwm_value[15:8]
  input  logic [tdsb_pkg::IN_USER_W-1:0]  s_tuser,     // opcode[2:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tdsb_pkg::OUT_DATA_W-1:0] m_tdata      // action[1:0], left_duty[9:2],
                                                       // right_duty[17:10], mode[19:18]
);
  import tdsb_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  result_t result;

  tdsb_input_reg u_input_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .take      (take),
    .item_valid(item_valid),
    .item      (item)
  );

  tdsb_core #(
    .PULSE_COUNT_WIDTH(PULSE_COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item      (item),
    .take      (take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  // Pack the result fields from the lowest bit up; the top four bits pad to zero.
  assign m_tdata = {4'b0000, result.mode, result.right_duty, result.left_duty, result.action};

endmodule

@@ sv/tdsb_input_reg.sv @@
module tdsb_input_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,
  input  logic [2:0]         s_tuser,
  input  logic               take,
  output logic               item_valid,
  output tdsb_pkg::item_t    item
);
  import tdsb_pkg::*;

  // The register refills in the same cycle that the core takes its word.
  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.opcode    <= opcode_t'(s_tuser);
      item.cmd_code  <= s_tdata[7:0];
      item.pwm_value <= s_tdata[15:8];
    end
  end

endmodule

@@ sv/tdsb_balance.sv @@
module tdsb_balance #(
  parameter int unsigned PULSE_COUNT_WIDTH = tdsb_pkg::PULSE_COUNT_WIDTH_DEF
) (
  input  logic [PULSE_COUNT_WIDTH-1:0] left_pulses,
  input  logic [PULSE_COUNT_WIDTH-1:0] right_pulses,
  input  logic [7:0]                   right_speed,
  output logic [7:0]                   right_speed_next
);
  import tdsb_pkg::*;

  // Any difference past CLAMP_MAX already drives the correction beyond the
  // full duty range, so the magnitude is clamped before scaling.
  localparam int unsigned CLAMP_W   = 13;
  localparam int unsigned EXT_W     = (PULSE_COUNT_WIDTH > CLAMP_W) ? PULSE_COUNT_WIDTH : CLAMP_W;
  localparam logic [EXT_W-1:0] CLAMP_MAX = EXT_W'((1 << CLAMP_W) - 1);
  // floor(x / 125) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2**16.
  localparam logic [16:0] RECIP = 17'd67109;
  localparam int unsigned RECIP_SHIFT = 23;

  logic                         negative;
  logic [PULSE_COUNT_WIDTH-1:0] mag;
  logic [EXT_W-1:0]             mag_ext;
  logic [CLAMP_W-1:0]           mag_clamped;
  logic [15:0]                  scaled;
  logic [32:0]                  product;
  logic [9:0]                   corr;
  logic signed [11:0]           sum;

  always_comb begin
    negative    = left_pulses < right_pulses;
    mag         = negative ? (right_pulses - left_pulses) : (left_pulses - right_pulses);
    mag_ext     = EXT_W'(mag);
    mag_clamped = (mag_ext > CLAMP_MAX) ? CLAMP_MAX[CLAMP_W-1:0] : mag_ext[CLAMP_W-1:0];
    // Times six as two shifted copies: four times plus two times.
    scaled      = {1'b0, mag_clamped, 2'b00} + {2'b00, mag_clamped, 1'b0};
    product     = 33'(scaled) * 33'(RECIP);
    corr        = product[RECIP_SHIFT +: 10];
    sum         = negative ? (12'(right_speed) - 12'(corr)) : (12'(right_speed) + 12'(corr));
    if (sum < 12'sd0) begin
      right_speed_next = 8'd0;
    end else if (sum > 12'sd255) begin
      right_speed_next = 8'd255;
    end else begin
      right_speed_next = sum[7:0];
    end
  end

endmodule

@@ sv/tdsb_core.sv @@
module tdsb_core #(
  parameter int unsigned PULSE_COUNT_WIDTH = tdsb_pkg::PULSE_COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tdsb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          item_valid,
  input  tdsb_pkg::item_t               item,
  output logic                          take,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output tdsb_pkg::result_t             result
);
  import tdsb_pkg::*;

  localparam logic [PULSE_COUNT_WIDTH-1:0] PULSE_MAX = '1;

  logic [7:0] move_ticks;
  logic [7:0] rest_ticks;

  mode_t                        drive_mode, drive_mode_next;
  logic [7:0]                   tick_count, tick_count_next;
  logic [PULSE_COUNT_WIDTH-1:0] left_pulses, left_pulses_next;
  logic [PULSE_COUNT_WIDTH-1:0] right_pulses, right_pulses_next;
  logic [7:0]                   left_speed, left_speed_next;
  logic [7:0]                   right_speed, right_speed_next;
  logic [7:0]                   balanced_speed;
  logic [7:0]                   tick_bumped;
  logic                         known_cmd;
  result_t                      result_next;

  assign take = item_valid && (!m_tvalid || m_tready);

  tdsb_balance #(
    .PULSE_COUNT_WIDTH(PULSE_COUNT_WIDTH)
  ) u_balance (
    .left_pulses     (left_pulses),
    .right_pulses    (right_pulses),
    .right_speed     (right_speed),
    .right_speed_next(balanced_speed)
  );

  assign tick_bumped = (tick_count == 8'hFF) ? 8'hFF : tick_count + 8'd1;
  assign known_cmd   = (item.cmd_code == CMD_FWD) || (item.cmd_code == CMD_BACK) ||
                       (item.cmd_code == CMD_STOP);

  // Next state.
  always_comb begin
    drive_mode_next   = drive_mode;
    tick_count_next   = tick_count;
    left_pulses_next  = left_pulses;
    right_pulses_next = right_pulses;
    left_speed_next   = left_speed;
    right_speed_next  = right_speed;
    unique case (item.opcode)
      OP_COMMAND: begin
        if (known_cmd) begin
          left_pulses_next  = '0;
          right_pulses_next = '0;
          if (item.cmd_code == CMD_STOP) begin
            left_speed_next  = 8'd0;
            right_speed_next = 8'd0;
            drive_mode_next  = MODE_IDLE;
          end else begin
            left_speed_next  = item.pwm_value;
            right_speed_next = item.pwm_value;
            drive_mode_next  = (item.cmd_code == CMD_FWD) ? MODE_FWD : MODE_BACK;
          end
        end
      end
      OP_STATE_TICK: begin
        unique case (drive_mode)
          MODE_IDLE: tick_count_next = 8'd0;
          MODE_REST: begin
            tick_count_next = tick_bumped;
            if (tick_bumped >= rest_ticks) begin
              tick_count_next = 8'd0;
              drive_mode_next = MODE_IDLE;
            end
          end
          default: begin
            tick_count_next = tick_bumped;
            if (tick_bumped >= move_ticks) begin
              tick_count_next = 8'd0;
              drive_mode_next = MODE_REST;
            end
          end
        endcase
      end
      OP_CTRL_TICK: begin
        right_speed_next  = balanced_speed;
        left_pulses_next  = '0;
        right_pulses_next = '0;
      end
      OP_LEFT_PULSE: begin
        if (left_pulses != PULSE_MAX) begin
          left_pulses_next = left_pulses + PULSE_COUNT_WIDTH'(1);
        end
      end
      OP_RIGHT_PULSE: begin
        if (right_pulses != PULSE_MAX) begin
          right_pulses_next = right_pulses + PULSE_COUNT_WIDTH'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result word.
  always_comb begin
    result_next.action     = ACT_NONE;
    result_next.left_duty  = 8'd0;
    result_next.right_duty = 8'd0;
    result_next.mode       = drive_mode_next;
    unique case (item.opcode)
      OP_COMMAND: begin
        if (known_cmd) begin
          if (item.cmd_code == CMD_STOP) begin
            result_next.action = ACT_STOP;
          end else begin
            result_next.action     = (item.cmd_code == CMD_FWD) ? ACT_FWD : ACT_BACK;
            result_next.left_duty  = item.pwm_value;
            result_next.right_duty = item.pwm_value;
          end
        end
      end
      OP_STATE_TICK: begin
        if (drive_mode == MODE_REST) begin
          result_next.action = ACT_STOP;
        end
      end
      OP_CTRL_TICK: begin
        if (drive_mode == MODE_FWD || drive_mode == MODE_BACK) begin
          result_next.action     = (drive_mode == MODE_FWD) ? ACT_FWD : ACT_BACK;
          result_next.left_duty  = left_speed;
          result_next.right_duty = balanced_speed;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_ticks <= MOVE_TICKS_RESET;
      rest_ticks <= REST_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOVE_TICKS: move_ticks <= cfg_data;
        CFG_REST_TICKS: rest_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= MODE_IDLE;
      tick_count   <= 8'd0;
      left_pulses  <= '0;
      right_pulses <= '0;
      left_speed   <= 8'd0;
      right_speed  <= 8'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (take) begin
        drive_mode   <= drive_mode_next;
        tick_count   <= tick_count_next;
        left_pulses  <= left_pulses_next;
        right_pulses <= right_pulses_next;
        left_speed   <= left_speed_next;
        right_speed  <= right_speed_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule
